### sv/bat_pkg.sv
// Shared types and constants for the box-average thumbnail block.
// Used by box_average_thumbnail; no other dependencies.
`default_nettype none

package bat_pkg;

    localparam int OUT_SIZE_DEF = 32;
    localparam int MAX_DIM_DEF  = 4096;

    localparam int CFG_W  = 13;
    localparam int PIX_W  = 8;
    localparam int AVG_W  = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CFG_W-1:0] DIM_RESET = 13'd32;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_RD,
        ST_LOAD,
        ST_DIV,
        ST_PUT
    } state_t;

endpackage

`default_nettype wire

### sv/box_average_thumbnail.sv
// Box-average thumbnail: raster gray pixels in, OUT_SIZE x OUT_SIZE cell averages out.
// Depends on bat_pkg for constants and the sequencer state type.
//
// For each pixel, the block first reads its column bin from the bin memory, then adds
// and writes it back. Bin and band positions are stepped with an add-and-compare, so no
// divider sits in the pixel path. After the last pixel of a band of source rows, the
// block reads every bin in turn and runs it through one shared restoring divider (one
// quotient bit a cycle). Pixels are held off until every cell of the band has gone to
// the output register. The last cell of a band may wait in the output register while
// pixels of the next band flow in. A write to either dimension register restarts the
// frame. Dimension values below OUT_SIZE are used as OUT_SIZE and those above MAX_DIM
// as MAX_DIM.
`default_nettype none

module box_average_thumbnail #(
    parameter int OUT_SIZE = bat_pkg::OUT_SIZE_DEF,
    parameter int MAX_DIM  = bat_pkg::MAX_DIM_DEF,
    localparam int BIN_W   = $clog2(OUT_SIZE)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bat_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bat_pkg::DATA_W-1:0] pwdata,
    output logic      [bat_pkg::DATA_W-1:0] prdata,
    output logic                            pready,

    input  wire logic                       pixel_valid,
    output logic                            pixel_ready,
    input  wire logic [bat_pkg::PIX_W-1:0]  pixel,

    output logic                            cell_valid,
    input  wire logic                       cell_ready,
    output logic      [bat_pkg::AVG_W-1:0]  average,
    output logic      [BIN_W-1:0]           out_row,
    output logic      [BIN_W-1:0]           out_col,
    output logic                            row_last
);

    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int SPAN     = (MAX_DIM + OUT_SIZE - 1) / OUT_SIZE;
    localparam int CELL_MAX = SPAN * SPAN;
    localparam int CNT_W    = $clog2(CELL_MAX + 1);
    localparam int SUM_W    = $clog2(longint'(CELL_MAX) * 255 + 1);
    localparam int STEP_W   = $clog2(SUM_W + 1);
    localparam int ENT_W    = SUM_W + CNT_W;

    localparam logic [DIM_W:0]   N_EXT    = (DIM_W + 1)'(OUT_SIZE);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(OUT_SIZE - 1);

    // configuration
    logic [bat_pkg::CFG_W-1:0] width_reg;
    logic [bat_pkg::CFG_W-1:0] height_reg;
    logic                      cfg_we;
    logic [DIM_W-1:0]          w_eff;
    logic [DIM_W-1:0]          h_eff;
    logic [31:0]               wv;
    logic [31:0]               hv;

    // sequencer and position state
    bat_pkg::state_t           state_reg,  state_next;
    logic [bat_pkg::PIX_W-1:0] pix_reg;
    logic [DIM_W-1:0]          col_reg,    col_next;
    logic [DIM_W-1:0]          cacc_reg,   cacc_next;
    logic [BIN_W-1:0]          bin_reg,    bin_next;
    logic [DIM_W-1:0]          row_reg,    row_next;
    logic [DIM_W-1:0]          racc_reg,   racc_next;
    logic [BIN_W-1:0]          band_reg,   band_next;
    logic [OUT_SIZE-1:0]       vld_reg,    vld_next;
    logic [BIN_W-1:0]          idx_reg,    idx_next;

    // shared divider
    logic [SUM_W-1:0]          dvd_reg,    dvd_next;
    logic [CNT_W-1:0]          dvs_reg,    dvs_next;
    logic [CNT_W-1:0]          rem_reg,    rem_next;
    logic [STEP_W-1:0]         step_reg,   step_next;
    logic [CNT_W:0]            trial;

    // output register
    logic                      ovld_reg,   ovld_next;
    logic [bat_pkg::AVG_W-1:0] avg_reg,    avg_next;
    logic [BIN_W-1:0]          orow_reg,   orow_next;
    logic [BIN_W-1:0]          ocol_reg,   ocol_next;
    logic                      olast_reg,  olast_next;
    logic                      out_load;

    // bin memory
    logic [ENT_W-1:0]          bin_mem [OUT_SIZE];
    logic [ENT_W-1:0]          rd_data_reg;
    logic [BIN_W-1:0]          rd_addr;
    logic                      mem_we;
    logic [ENT_W-1:0]          wr_data;
    logic [SUM_W-1:0]          rd_sum;
    logic [CNT_W-1:0]          rd_cnt;

    // position stepping
    logic [DIM_W:0]            csum;
    logic [DIM_W:0]            rsum;
    logic                      row_end;
    logic                      last_row;
    logic                      band_end;
    logic [DIM_W-1:0]          row_adv;
    logic [DIM_W-1:0]          racc_adv;
    logic [BIN_W-1:0]          band_adv;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            bat_pkg::REG_WIDTH:  prdata = bat_pkg::DATA_W'(width_reg);
            bat_pkg::REG_HEIGHT: prdata = bat_pkg::DATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bat_pkg::DIM_RESET;
            height_reg <= bat_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                bat_pkg::REG_WIDTH:  width_reg  <= pwdata[bat_pkg::CFG_W-1:0];
                bat_pkg::REG_HEIGHT: height_reg <= pwdata[bat_pkg::CFG_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    // clamp the dimensions into the usable range
    always_comb
    begin
        wv = 32'(width_reg);
        hv = 32'(height_reg);
        if (wv < 32'(OUT_SIZE))
            w_eff = DIM_W'(OUT_SIZE);
        else if (wv > 32'(MAX_DIM))
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = DIM_W'(wv);
        if (hv < 32'(OUT_SIZE))
            h_eff = DIM_W'(OUT_SIZE);
        else if (hv > 32'(MAX_DIM))
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = DIM_W'(hv);
    end

    // ------------------------------------------------------------------
    // bin memory: one read and one write port, registered read
    // ------------------------------------------------------------------
    assign rd_addr = (state_reg == bat_pkg::ST_RD) ? idx_reg : bin_reg;
    assign rd_sum  = vld_reg[bin_reg] ? rd_data_reg[ENT_W-1:CNT_W] : '0;
    assign rd_cnt  = vld_reg[bin_reg] ? rd_data_reg[CNT_W-1:0] : '0;
    assign mem_we  = (state_reg == bat_pkg::ST_ACC) && !cfg_we;
    assign wr_data = {rd_sum + SUM_W'(pix_reg), rd_cnt + CNT_W'(1)};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[bin_reg] <= wr_data;
        rd_data_reg <= bin_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // position stepping: bin = col*OUT_SIZE/w kept as quotient and remainder
    // ------------------------------------------------------------------
    assign csum     = {1'b0, cacc_reg} + N_EXT;
    assign rsum     = {1'b0, racc_reg} + N_EXT;
    assign row_end  = (col_reg == w_eff - DIM_W'(1));
    assign last_row = (row_reg == h_eff - DIM_W'(1));
    assign band_end = last_row || (rsum >= {1'b0, h_eff});

    always_comb
    begin
        if (last_row)
        begin
            row_adv  = '0;
            racc_adv = '0;
            band_adv = '0;
        end
        else if (rsum >= {1'b0, h_eff})
        begin
            row_adv  = row_reg + DIM_W'(1);
            racc_adv = DIM_W'(rsum - {1'b0, h_eff});
            band_adv = band_reg + BIN_W'(1);
        end
        else
        begin
            row_adv  = row_reg + DIM_W'(1);
            racc_adv = DIM_W'(rsum);
            band_adv = band_reg;
        end
    end

    assign trial = {rem_reg, dvd_reg[SUM_W-1]};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        cacc_next  = cacc_reg;
        bin_next   = bin_reg;
        row_next   = row_reg;
        racc_next  = racc_reg;
        band_next  = band_reg;
        vld_next   = vld_reg;
        idx_next   = idx_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        avg_next   = avg_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        olast_next = olast_reg;
        out_load   = 1'b0;
        ovld_next  = ovld_reg && !cell_ready;

        case (state_reg)
            bat_pkg::ST_IDLE:
            begin
                if (pixel_valid)
                    state_next = bat_pkg::ST_ACC;
            end

            bat_pkg::ST_ACC:
            begin
                vld_next[bin_reg] = 1'b1;
                if (row_end)
                begin
                    col_next  = '0;
                    cacc_next = '0;
                    bin_next  = '0;
                    if (band_end)
                    begin
                        idx_next   = '0;
                        state_next = bat_pkg::ST_RD;
                    end
                    else
                    begin
                        row_next   = row_adv;
                        racc_next  = racc_adv;
                        band_next  = band_adv;
                        state_next = bat_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    col_next = col_reg + DIM_W'(1);
                    if (csum >= {1'b0, w_eff})
                    begin
                        cacc_next = DIM_W'(csum - {1'b0, w_eff});
                        bin_next  = bin_reg + BIN_W'(1);
                    end
                    else
                        cacc_next = DIM_W'(csum);
                    state_next = bat_pkg::ST_IDLE;
                end
            end

            bat_pkg::ST_RD:
            begin
                state_next = bat_pkg::ST_LOAD;
            end

            bat_pkg::ST_LOAD:
            begin
                // bin_reg is zero during emission, so look up validity by idx
                dvd_next   = vld_reg[idx_reg] ? rd_data_reg[ENT_W-1:CNT_W] : '0;
                dvs_next   = vld_reg[idx_reg] ? rd_data_reg[CNT_W-1:0] : '0;
                rem_next   = '0;
                step_next  = STEP_W'(SUM_W);
                state_next = bat_pkg::ST_DIV;
            end

            bat_pkg::ST_DIV:
            begin
                // one quotient bit a cycle, shifted into the dividend register
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                    state_next = bat_pkg::ST_PUT;
            end

            bat_pkg::ST_PUT:
            begin
                if (!ovld_reg || cell_ready)
                begin
                    out_load   = 1'b1;
                    ovld_next  = 1'b1;
                    avg_next   = (dvs_reg == '0) ? '0 : dvd_reg[bat_pkg::AVG_W-1:0];
                    orow_next  = band_reg;
                    ocol_next  = idx_reg;
                    olast_next = (idx_reg == BIN_LAST);
                    if (idx_reg == BIN_LAST)
                    begin
                        vld_next   = '0;
                        row_next   = row_adv;
                        racc_next  = racc_adv;
                        band_next  = band_adv;
                        state_next = bat_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + BIN_W'(1);
                        state_next = bat_pkg::ST_RD;
                    end
                end
            end

            default:
            begin
                state_next = bat_pkg::ST_IDLE;
            end
        endcase

        // a dimension write restarts the frame
        if (cfg_we)
        begin
            state_next = bat_pkg::ST_IDLE;
            col_next   = '0;
            cacc_next  = '0;
            bin_next   = '0;
            row_next   = '0;
            racc_next  = '0;
            band_next  = '0;
            vld_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bat_pkg::ST_IDLE;
            col_reg   <= '0;
            cacc_reg  <= '0;
            bin_reg   <= '0;
            row_reg   <= '0;
            racc_reg  <= '0;
            band_reg  <= '0;
            vld_reg   <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            cacc_reg  <= cacc_next;
            bin_reg   <= bin_next;
            row_reg   <= row_next;
            racc_reg  <= racc_next;
            band_reg  <= band_next;
            vld_reg   <= vld_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && pixel_ready)
            pix_reg <= pixel;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        if (out_load)
        begin
            avg_reg   <= avg_next;
            orow_reg  <= orow_next;
            ocol_reg  <= ocol_next;
            olast_reg <= olast_next;
        end
    end

    assign pixel_ready = (state_reg == bat_pkg::ST_IDLE);
    assign cell_valid  = ovld_reg;
    assign average     = avg_reg;
    assign out_row     = orow_reg;
    assign out_col     = ocol_reg;
    assign row_last    = olast_reg;

`ifndef SYNTHESIS
    a_cacc_range: assert property (@(posedge clk) disable iff (!rst_n)
        cacc_reg < w_eff)
        else $error("column remainder out of range");

    a_racc_range: assert property (@(posedge clk) disable iff (!rst_n)
        racc_reg < h_eff)
        else $error("row remainder out of range");

    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg == '0 |-> (bin_reg == '0 && cacc_reg == '0))
        else $error("bin position not reset at row start");

    a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bat_pkg::ST_ACC |-> $past(pixel_valid && pixel_ready))
        else $error("accumulate step without an accepted word");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bat_pkg::ST_DIV |-> step_reg != '0)
        else $error("divider ran past its last step");
`endif

endmodule

`default_nettype wire
